@@ src/sbrs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbrs_pkg
// Shared widths, constants, the sideband type and helpers of the swept box slab test.
// ----------------------------------------------------------------------------
package sbrs_pkg;

  localparam int COORD_W   = 32;
  localparam int SIZE_W    = 31;
  localparam int OFF_W     = 35;
  localparam int TIME_BITS = 16;
  localparam int QB        = 17;
  localparam int NUM_W     = OFF_W + TIME_BITS;
  localparam int T_W       = 20;
  localparam int DIV_LAT   = QB + 3;
  localparam int CONT_LAT  = 2;

  localparam logic signed [T_W-1:0] T_ONE  = T_W'(1) <<< TIME_BITS;
  localparam logic signed [T_W-1:0] T_SAT  = T_W'(1) <<< QB;
  localparam logic signed [T_W-1:0] T_UNB  = T_W'(1) <<< (QB + 1);

  localparam logic signed [1:0] NRM_POS  = 2'sb01;
  localparam logic signed [1:0] NRM_NEG  = 2'sb11;
  localparam logic signed [1:0] NRM_ZERO = 2'sb00;

  typedef struct packed {
    logic                      rule;
    logic signed [COORD_W-1:0] mx;
    logic signed [COORD_W-1:0] my;
    logic        [SIZE_W-1:0]  mw;
    logic        [SIZE_W-1:0]  mh;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic                      zx;
    logic                      zy;
    logic                      inx;
    logic                      iny;
  } sbrs_side_t;

  function automatic logic signed [OFF_W-1:0] sx_coord(input logic [COORD_W-1:0] v);
    return $signed({{(OFF_W-COORD_W){v[COORD_W-1]}}, v});
  endfunction

  function automatic logic signed [OFF_W-1:0] zx_size(input logic [SIZE_W-1:0] v);
    return $signed({{(OFF_W-SIZE_W){1'b0}}, v});
  endfunction

endpackage
`default_nettype wire

@@ src/sbrs_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbrs_div
// Pipelined floor division of an offset scaled by 2^16 by a velocity,
// one quotient bit per stage, result clamped to a narrow signed range.
// ----------------------------------------------------------------------------
module sbrs_div import sbrs_pkg::*; (
  input  wire logic                      clk,
  input  wire logic signed [OFF_W-1:0]   num,
  input  wire logic signed [COORD_W-1:0] den,
  output logic signed [T_W-1:0]          quo
);

  logic [NUM_W-1:0]   nm;
  logic [COORD_W-1:0] dm;
  logic               ng;

  logic [NUM_W-1:0]   rem [0:QB];
  logic [QB-1:0]      qb  [0:QB];
  logic [COORD_W-1:0] dv  [0:QB];
  logic               ngv [0:QB];
  logic               sat [0:QB];

  logic [OFF_W-1:0]   num_abs;
  logic [COORD_W-1:0] den_abs;

  assign num_abs = num[OFF_W-1] ? OFF_W'(-num) : OFF_W'(num);
  assign den_abs = den[COORD_W-1] ? COORD_W'(-den) : COORD_W'(den);

  always_ff @(posedge clk) begin
    nm <= NUM_W'(num_abs) << TIME_BITS;
    dm <= den_abs;
    ng <= num[OFF_W-1] ^ den[COORD_W-1];

    rem[0] <= nm;
    qb[0]  <= '0;
    dv[0]  <= dm;
    ngv[0] <= ng;
    sat[0] <= nm >= (NUM_W'(dm) << QB);

    for (int k = 0; k < QB; k++) begin
      if (rem[k] >= (NUM_W'(dv[k]) << (QB - 1 - k))) begin
        rem[k+1] <= rem[k] - (NUM_W'(dv[k]) << (QB - 1 - k));
        qb[k+1]  <= qb[k] | (QB'(1) << (QB - 1 - k));
      end else begin
        rem[k+1] <= rem[k];
        qb[k+1]  <= qb[k];
      end
      dv[k+1]  <= dv[k];
      ngv[k+1] <= ngv[k];
      sat[k+1] <= sat[k];
    end

    if (sat[QB]) begin
      quo <= ngv[QB] ? -T_SAT : T_SAT;
    end else if (ngv[QB]) begin
      quo <= -$signed(T_W'(qb[QB])) - ((rem[QB] != '0) ? T_W'(1) : T_W'(0));
    end else begin
      quo <= $signed(T_W'(qb[QB]));
    end
  end

endmodule
`default_nettype wire

@@ src/sbrs_contact.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbrs_contact
// Mover centre at the entry time along one axis, floored and saturated.
// ----------------------------------------------------------------------------
module sbrs_contact import sbrs_pkg::*; (
  input  wire logic                      clk,
  input  wire logic signed [COORD_W-1:0] corner,
  input  wire logic        [SIZE_W-1:0]  size,
  input  wire logic signed [T_W-1:0]     t,
  input  wire logic signed [COORD_W-1:0] vel,
  output logic signed [COORD_W-1:0]      coord
);

  localparam int SUM_W = T_W + COORD_W;
  localparam int SH_W  = SUM_W - TIME_BITS;

  logic signed [SUM_W-1:0] prod;
  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] sum;
  logic signed [SH_W-1:0]  shr;
  logic signed [COORD_W+1:0] twice;

  assign twice = $signed({corner[COORD_W-1], corner, 1'b0}) + $signed({3'b000, size});
  assign sum   = prod + base;
  assign shr   = SH_W'(sum >>> TIME_BITS);

  always_ff @(posedge clk) begin
    prod <= SUM_W'(t) * SUM_W'(vel);
    base <= SUM_W'(twice) <<< (TIME_BITS - 1);
    if (shr > SH_W'(33'sh0_7FFF_FFFF)) begin
      coord <= 32'sh7FFF_FFFF;
    end else if (shr < -SH_W'(33'sh0_8000_0000)) begin
      coord <= 32'sh8000_0000;
    end else begin
      coord <= COORD_W'(shr);
    end
  end

endmodule
`default_nettype wire

@@ src/swept_box_ray_slab_test.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swept_box_ray_slab_test
// Swept box against box slab test in 2D with hit, contact, normal and time.
// ----------------------------------------------------------------------------
// A request is taken in every cycle (busy stays low) and its result appears
// with done after one input register, the four bit-per-stage dividers, a
// register after the slab compares, the contact multiply and add registers
// and one output register. Results cannot be held off.
module swept_box_ray_slab_test import sbrs_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      req_type,
  input  wire logic signed [COORD_W-1:0] mover_x,
  input  wire logic signed [COORD_W-1:0] mover_y,
  input  wire logic        [SIZE_W-1:0]  mover_w,
  input  wire logic        [SIZE_W-1:0]  mover_h,
  input  wire logic signed [COORD_W-1:0] vel_x,
  input  wire logic signed [COORD_W-1:0] vel_y,
  input  wire logic signed [COORD_W-1:0] target_x,
  input  wire logic signed [COORD_W-1:0] target_y,
  input  wire logic        [SIZE_W-1:0]  target_w,
  input  wire logic        [SIZE_W-1:0]  target_h,
  output logic                           done,
  output logic                           hit,
  output logic signed [COORD_W-1:0]      contact_x,
  output logic signed [COORD_W-1:0]      contact_y,
  output logic signed [1:0]              normal_x,
  output logic signed [1:0]              normal_y,
  output logic        [TIME_BITS-1:0]    hit_time
);

  assign busy = 1'b0;

  // input stage
  logic                      s0_vld;
  logic                      s0_rule;
  logic signed [COORD_W-1:0] s0_mx, s0_my, s0_vx, s0_vy;
  logic        [SIZE_W-1:0]  s0_mw, s0_mh;
  logic signed [OFF_W-1:0]   s0_nx, s0_fx, s0_ny, s0_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else begin
      s0_vld <= start;
    end
    s0_rule <= req_type;
    s0_mx   <= mover_x;
    s0_my   <= mover_y;
    s0_mw   <= mover_w;
    s0_mh   <= mover_h;
    s0_vx   <= vel_x;
    s0_vy   <= vel_y;
    s0_nx   <= sx_coord(target_x) - sx_coord(mover_x) - zx_size(mover_w);
    s0_fx   <= sx_coord(target_x) + zx_size(target_w) - sx_coord(mover_x);
    s0_ny   <= sx_coord(target_y) - sx_coord(mover_y) - zx_size(mover_h);
    s0_fy   <= sx_coord(target_y) + zx_size(target_h) - sx_coord(mover_y);
  end

  // dividers
  logic signed [T_W-1:0] q_nx, q_fx, q_ny, q_fy;

  sbrs_div u_div_nx (.clk(clk), .num(s0_nx), .den(s0_vx), .quo(q_nx));
  sbrs_div u_div_fx (.clk(clk), .num(s0_fx), .den(s0_vx), .quo(q_fx));
  sbrs_div u_div_ny (.clk(clk), .num(s0_ny), .den(s0_vy), .quo(q_ny));
  sbrs_div u_div_fy (.clk(clk), .num(s0_fy), .den(s0_vy), .quo(q_fy));

  // sideband line alongside the dividers
  sbrs_side_t sb_in;
  sbrs_side_t sb  [1:DIV_LAT];
  logic       vl  [1:DIV_LAT];

  always_comb begin
    sb_in.rule = s0_rule;
    sb_in.mx   = s0_mx;
    sb_in.my   = s0_my;
    sb_in.mw   = s0_mw;
    sb_in.mh   = s0_mh;
    sb_in.vx   = s0_vx;
    sb_in.vy   = s0_vy;
    sb_in.zx   = (s0_vx == '0);
    sb_in.zy   = (s0_vy == '0);
    sb_in.inx  = (s0_nx < 0) && (s0_fx > 0);
    sb_in.iny  = (s0_ny < 0) && (s0_fy > 0);
  end

  always_ff @(posedge clk) begin
    sb[1] <= sb_in;
    if (rst) begin
      vl[1] <= 1'b0;
    end else begin
      vl[1] <= s0_vld;
    end
    for (int k = 1; k < DIV_LAT; k++) begin
      sb[k+1] <= sb[k];
      if (rst) begin
        vl[k+1] <= 1'b0;
      end else begin
        vl[k+1] <= vl[k];
      end
    end
  end

  // slab compare
  sbrs_side_t            sd;
  logic signed [T_W-1:0] tnx, tfx, tny, tfy, tn, tf, tabs;
  logic                  miss, acc;
  logic signed [1:0]     nrx, nry;

  assign sd = sb[DIV_LAT];

  always_comb begin
    miss = 1'b0;
    if (sd.zx) begin
      tnx  = -T_UNB;
      tfx  = T_UNB;
      miss = !sd.inx;
    end else if (q_nx > q_fx) begin
      tnx = q_fx;
      tfx = q_nx;
    end else begin
      tnx = q_nx;
      tfx = q_fx;
    end
    if (sd.zy) begin
      tny = -T_UNB;
      tfy = T_UNB;
      if (!sd.iny) begin
        miss = 1'b1;
      end
    end else if (q_ny > q_fy) begin
      tny = q_fy;
      tfy = q_ny;
    end else begin
      tny = q_ny;
      tfy = q_fy;
    end
    if ((tnx > tfy) || (tny > tfx)) begin
      miss = 1'b1;
    end
    tn   = (tnx > tny) ? tnx : tny;
    tf   = (tfx < tfy) ? tfx : tfy;
    tabs = (tn < 0) ? -tn : tn;
    if (tf < 0) begin
      miss = 1'b1;
    end
    if (sd.rule) begin
      acc = !miss && (tabs < T_ONE);
    end else begin
      acc = !miss && (tn >= 0) && (tn < T_ONE);
    end
    nrx = NRM_ZERO;
    nry = NRM_ZERO;
    if (tnx > tny) begin
      nrx = sd.vx[COORD_W-1] ? NRM_POS : NRM_NEG;
    end else if (tnx < tny) begin
      nry = sd.vy[COORD_W-1] ? NRM_POS : NRM_NEG;
    end
  end

  logic                      e_vld;
  logic                      e_hit;
  logic signed [T_W-1:0]     e_tn;
  logic signed [1:0]         e_nrx, e_nry;
  logic [TIME_BITS-1:0]      e_tout;
  sbrs_side_t                e_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= vl[DIV_LAT];
    end
    e_hit  <= acc;
    e_tn   <= tn;
    e_nrx  <= nrx;
    e_nry  <= nry;
    e_tout <= tabs[TIME_BITS-1:0];
    e_sd   <= sd;
  end

  // contact point
  logic signed [COORD_W-1:0] cx, cy;

  sbrs_contact u_cont_x (
    .clk(clk), .corner(e_sd.mx), .size(e_sd.mw), .t(e_tn), .vel(e_sd.vx), .coord(cx)
  );
  sbrs_contact u_cont_y (
    .clk(clk), .corner(e_sd.my), .size(e_sd.mh), .t(e_tn), .vel(e_sd.vy), .coord(cy)
  );

  logic                 d_vld [1:CONT_LAT];
  logic                 d_hit [1:CONT_LAT];
  logic signed [1:0]    d_nrx [1:CONT_LAT];
  logic signed [1:0]    d_nry [1:CONT_LAT];
  logic [TIME_BITS-1:0] d_tm  [1:CONT_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld[1] <= 1'b0;
    end else begin
      d_vld[1] <= e_vld;
    end
    d_hit[1] <= e_hit;
    d_nrx[1] <= e_nrx;
    d_nry[1] <= e_nry;
    d_tm[1]  <= e_tout;
    for (int k = 1; k < CONT_LAT; k++) begin
      if (rst) begin
        d_vld[k+1] <= 1'b0;
      end else begin
        d_vld[k+1] <= d_vld[k];
      end
      d_hit[k+1] <= d_hit[k];
      d_nrx[k+1] <= d_nrx[k];
      d_nry[k+1] <= d_nry[k];
      d_tm[k+1]  <= d_tm[k];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_vld[CONT_LAT];
    end
    hit <= d_hit[CONT_LAT];
    if (d_hit[CONT_LAT]) begin
      contact_x <= cx;
      contact_y <= cy;
      normal_x  <= d_nrx[CONT_LAT];
      normal_y  <= d_nry[CONT_LAT];
      hit_time  <= d_tm[CONT_LAT];
    end else begin
      contact_x <= '0;
      contact_y <= '0;
      normal_x  <= NRM_ZERO;
      normal_y  <= NRM_ZERO;
      hit_time  <= '0;
    end
  end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives box pairs into the swept box slab test, predicts hit, contact,
// normal and time for each request and checks every done pulse in order.
// ----------------------------------------------------------------------------
module testbench;
  import sbrs_pkg::*;

  localparam longint TONE = 64'sd65536;
  localparam longint UNB  = 64'sd1 <<< 60;

  typedef struct {
    logic                      hit;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [1:0]         nx;
    logic signed [1:0]         ny;
    logic [TIME_BITS-1:0]      t;
  } slab_hit_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic req_type = 0;
  logic signed [COORD_W-1:0] mover_x = 0, mover_y = 0, vel_x = 0, vel_y = 0;
  logic signed [COORD_W-1:0] target_x = 0, target_y = 0;
  logic [SIZE_W-1:0] mover_w = 0, mover_h = 0, target_w = 0, target_h = 0;
  logic done, hit;
  logic signed [COORD_W-1:0] contact_x, contact_y;
  logic signed [1:0] normal_x, normal_y;
  logic [TIME_BITS-1:0] hit_time;

  slab_hit_t pending_hits[$];
  int errors = 0;
  bit gaps_on = 1;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  swept_box_ray_slab_test u_top (.*);

  function automatic longint fdiv(longint n, longint d);
    longint q, r;
    q = n / d;
    r = n % d;
    if (r != 0 && ((r < 0) != (d < 0))) q--;
    return q;
  endfunction

  function automatic bit slab_times(longint lo, longint hi, longint v,
                                    output longint tn, output longint tf);
    longint a, b;
    tn = 0;
    tf = 0;
    if (v == 0) begin
      if (lo < 0 && hi > 0) begin
        tn = -UNB;
        tf = UNB;
        return 1;
      end
      return 0;
    end
    a = fdiv(lo * TONE, v);
    b = fdiv(hi * TONE, v);
    tn = (a > b) ? b : a;
    tf = (a > b) ? a : b;
    return 1;
  endfunction

  function automatic logic [31:0] centre_at(longint c, longint s, longint t, longint v);
    longint q;
    q = fdiv((2 * c + s) * TONE + 2 * t * v, 2 * TONE);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic slab_hit_t predict_sweep(bit rule, longint mx, longint my,
      longint mw, longint mh, longint vx, longint vy, longint tx, longint ty,
      longint tw, longint th);
    slab_hit_t r;
    longint nx, fx, ny, fy, tnear, tfar, tout;
    r = '{0, 0, 0, NRM_ZERO, NRM_ZERO, 0};
    if (!slab_times(tx - mx - mw, tx + tw - mx, vx, nx, fx)) return r;
    if (!slab_times(ty - my - mh, ty + th - my, vy, ny, fy)) return r;
    if (nx > fy || ny > fx) return r;
    tnear = nx > ny ? nx : ny;
    tfar = fx < fy ? fx : fy;
    if (tfar < 0) return r;
    if (rule) begin
      tout = tnear < 0 ? -tnear : tnear;
      if (tout >= TONE) return r;
    end else begin
      if (tnear < 0 || tnear >= TONE) return r;
      tout = tnear;
    end
    if (nx > ny) r.nx = vx < 0 ? NRM_POS : NRM_NEG;
    else if (nx < ny) r.ny = vy < 0 ? NRM_POS : NRM_NEG;
    r.hit = 1;
    r.cx = centre_at(mx, mw, tnear, vx);
    r.cy = centre_at(my, mh, tnear, vy);
    r.t = tout[15:0];
    return r;
  endfunction

  task automatic send_pair(bit rule, logic [31:0] mx, logic [31:0] my,
      logic [30:0] mw, logic [30:0] mh, logic [31:0] vx, logic [31:0] vy,
      logic [31:0] tx, logic [31:0] ty, logic [30:0] tw, logic [30:0] th);
    int g;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 0;
      g = $urandom_range(1, 14);
      repeat (g) @(posedge clk);
    end
    start <= 1;
    req_type <= rule;
    mover_x <= mx; mover_y <= my; mover_w <= mw; mover_h <= mh;
    vel_x <= vx; vel_y <= vy;
    target_x <= tx; target_y <= ty; target_w <= tw; target_h <= th;
    do @(posedge clk); while (busy);
    pending_hits.push_back(predict_sweep(rule, $signed(mx), $signed(my), mw, mh,
        $signed(vx), $signed(vy), $signed(tx), $signed(ty), tw, th));
  endtask

  always @(posedge clk) begin
    slab_hit_t e;
    if (!rst && done) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result hit=%0d", $time, hit);
        errors++;
      end else begin
        e = pending_hits.pop_front();
        if (hit !== e.hit || contact_x !== e.cx || contact_y !== e.cy ||
            normal_x !== e.nx || normal_y !== e.ny || hit_time !== e.t) begin
          $display("%0t: mismatch expected %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                   $time, e.hit, e.cx, e.cy, e.nx, e.ny, e.t, hit, contact_x,
                   contact_y, normal_x, normal_y, hit_time);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_pair(0, 0, 0, 2560, 2560, 2560, 0, 5120, 0, 2560, 2560);
    send_pair(1, 0, 0, 2560, 2560, 2560, 0, 5120, 0, 2560, 2560);
    send_pair(0, 0, 0, 256, 256, 2560, 2560, 1280, 1280, 512, 512);
    send_pair(0, 0, 0, 256, 256, 0, 0, 1280, 1280, 512, 512);
    send_pair(0, 0, 0, 256, 256, 0, 512, -128, 1280, 512, 512);
    send_pair(0, 0, 0, 256, 256, 0, 512, 256, 1280, 512, 512);
    send_pair(0, 2048, 0, 256, 256, -2560, 0, 0, 0, 512, 256);
    send_pair(1, 2048, 0, 256, 256, 2560, 0, 0, 0, 512, 256);
    send_pair(0, 2048, 0, 256, 256, 2560, 0, 0, 0, 512, 256);
    send_pair(1, 0, 0, 256, 256, 512, 0, 0, 0, 512, 256);
    send_pair(0, 32'h7fffffff, 32'h80000000, 31'h7fffffff, 31'h7fffffff,
              32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              31'h7fffffff, 31'h7fffffff);
    send_pair(1, 32'h80000000, 32'h7fffffff, 0, 0, 32'h7fffffff,
              32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0);
    send_pair(0, 32'h7fff0000, 0, 31'h7fffffff, 256, 32'h7fffffff, 1, 32'h7fffff00,
              0, 31'h7fffffff, 512);
    send_pair(1, -32'sd1, -32'sd1, 1, 1, -32'sd1, -32'sd1, 0, 0, 0, 0);
  endtask

  task automatic test_random(int n, bit wide);
    logic [31:0] mx, my, vx, vy, tx, ty;
    logic [30:0] mw, mh, tw, th;
    int s;
    for (int i = 0; i < n; i++) begin
      if (wide && $urandom_range(0, 3) == 0) begin
        mx = $urandom; my = $urandom; vx = $urandom; vy = $urandom;
        tx = $urandom; ty = $urandom;
        mw = $urandom; mh = $urandom; tw = $urandom; th = $urandom;
      end else begin
        s = $urandom_range(8, 20);
        mx = $signed($urandom_range(0, 1 << s)) - (1 << (s - 1));
        my = $signed($urandom_range(0, 1 << s)) - (1 << (s - 1));
        mw = $urandom_range(0, 1 << (s - 2));
        mh = $urandom_range(0, 1 << (s - 2));
        tw = $urandom_range(0, 1 << (s - 1));
        th = $urandom_range(0, 1 << (s - 1));
        tx = mx + $signed($urandom_range(0, 1 << s)) - (1 << (s - 1));
        ty = my + $signed($urandom_range(0, 1 << s)) - (1 << (s - 1));
        vx = (tx - mx) + $signed($urandom_range(0, 1 << (s - 1))) - (1 << (s - 2));
        vy = (ty - my) + $signed($urandom_range(0, 1 << (s - 1))) - (1 << (s - 2));
        if ($urandom_range(0, 7) == 0) vx = 0;
        if ($urandom_range(0, 7) == 0) vy = 0;
        if ($urandom_range(0, 15) == 0) vx = -vx;
      end
      send_pair($urandom_range(0, 1), mx, my, mw, mh, vx, vy, tx, ty, tw, th);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    test_directed();
    test_random(1500, 1);
    gaps_on = 0;
    test_random(300, 1);
    start <= 0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
src/sbrs_pkg.sv
src/sbrs_div.sv
src/sbrs_contact.sv
src/swept_box_ray_slab_test.sv
tb/testbench.sv
